### rtl/e20s_pkg.sv
// Shared request codes, opcodes, function codes and result record for the instruction-step block.
package e20s_pkg;

	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_EXEC  = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	localparam logic [2:0] OP_ALU  = 3'd0;
	localparam logic [2:0] OP_ADDI = 3'd1;
	localparam logic [2:0] OP_J    = 3'd2;
	localparam logic [2:0] OP_JAL  = 3'd3;
	localparam logic [2:0] OP_LW   = 3'd4;
	localparam logic [2:0] OP_SW   = 3'd5;
	localparam logic [2:0] OP_JEQ  = 3'd6;
	localparam logic [2:0] OP_SLTI = 3'd7;

	localparam logic [3:0] FN_ADD = 4'd0;
	localparam logic [3:0] FN_SUB = 4'd1;
	localparam logic [3:0] FN_OR  = 4'd2;
	localparam logic [3:0] FN_AND = 4'd3;
	localparam logic [3:0] FN_SLT = 4'd4;
	localparam logic [3:0] FN_JR  = 4'd8;

	localparam logic [2:0] LINK_REG = 3'd7;

	typedef struct packed {
		logic [15:0] prog_counter;
		logic        halted;
		logic [15:0] read_data;
		logic [15:0] reg_one;
		logic [15:0] reg_two;
		logic [15:0] reg_three;
		logic [15:0] reg_four;
		logic [15:0] reg_five;
		logic [15:0] reg_six;
		logic [15:0] reg_seven;
	} res_t;

endpackage

### rtl/e20s_req_if.sv
// Request channel: valid/ready handshake with the request word.
interface e20s_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [12:0] mem_addr;
	logic [15:0] write_data;

	modport source (output valid, output req_type, output mem_addr, output write_data,
		input ready);
	modport sink (input valid, input req_type, input mem_addr, input write_data,
		output ready);
endinterface

### rtl/e20s_rsp_if.sv
// Result channel: valid/ready handshake with the processor state word.
interface e20s_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] prog_counter;
	logic        halted;
	logic [15:0] read_data;
	logic [15:0] reg_one;
	logic [15:0] reg_two;
	logic [15:0] reg_three;
	logic [15:0] reg_four;
	logic [15:0] reg_five;
	logic [15:0] reg_six;
	logic [15:0] reg_seven;

	modport source (output valid, output prog_counter, output halted, output read_data,
		output reg_one, output reg_two, output reg_three, output reg_four, output reg_five,
		output reg_six, output reg_seven, input ready);
	modport sink (input valid, input prog_counter, input halted, input read_data,
		input reg_one, input reg_two, input reg_three, input reg_four, input reg_five,
		input reg_six, input reg_seven, output ready);
endinterface

### rtl/sixteen_bit_risc_instruction_step_top.sv
// Top level: 16-bit eight-register processor stepped one request word at a time.
//
//  channel | dir | word                                          | handshake
//  --------+-----+-----------------------------------------------+------------
//  req     | in  | req_type, mem_addr, write_data                | valid/ready
//  rsp     | out | prog_counter, halted, read_data, reg_one..7   | valid/ready
//
// Memory writes, memory reads and no-op requests: one word per cycle while rsp does not stall.
// Execute: fetch, then decode/execute/write back; no new word is taken meanwhile. lw reads
// its data through the read port of the main memory, and its write back to the register file
// overlaps the acceptance of the next word, with its result registered after that write back.
// After reset the main memory is cleared, one word a cycle, and req.ready stays low until the
// clear is done. Results wait in an output register; a stalled rsp holds the pipeline, and
// req.ready is also low while a held stage cannot move or an instruction executes.
module sixteen_bit_risc_instruction_step_top #(
	parameter int MEMORY_WORDS = 8192
) (
	input  logic            clk,
	input  logic            arst_n,
	e20s_req_if.sink        req,
	e20s_rsp_if.source      rsp
);
	import e20s_pkg::*;

	localparam int AW = $clog2(MEMORY_WORDS);

	typedef logic [63:0][12:0] modtbl_t;

	function automatic modtbl_t mod_tbl_build();
		modtbl_t t;
		for (int h = 0; h < 64; h++) begin
			t[h] = 13'((h * 128) % MEMORY_WORDS);
		end
		return t;
	endfunction

	localparam modtbl_t MOD_TBL = mod_tbl_build();

	function automatic logic [AW-1:0] map_addr(input logic [12:0] a);
		logic [13:0] s;
		s = 14'(MOD_TBL[a[12:7]]) + 14'(a[6:0]);
		if (s >= 14'(MEMORY_WORDS)) begin
			s = s - 14'(MEMORY_WORDS);
		end
		return s[AW-1:0];
	endfunction

	logic [15:0]   mem [MEMORY_WORDS];
	logic [15:0]   rdata_q;
	logic          clr_busy_q;
	logic [AW-1:0] clr_q;

	logic [15:0]   rf_q [8];
	logic [15:0]   rf_nxt [8];
	logic [15:0]   pc_q;
	logic          halt_q;

	logic          vld_s1;
	logic [1:0]    kind_s1;
	logic          vld_s2;
	logic [2:0]    dst_s2;

	logic          out_v_q;
	res_t          out_q;
	res_t          res;

	logic          acc, rdy, out_free, s1_adv, s2_adv, s1_exec, s1_lw, out_load;

	logic [2:0]    op, ra, rb, rc;
	logic [3:0]    fn;
	logic [15:0]   imm7, imm13, va, vb, pc_inc, nxt, dsum;
	logic [AW-1:0] daddr;
	logic          x_we, x_lw, x_sw;
	logic [2:0]    x_idx;
	logic [15:0]   x_val;

	logic          wr_en;
	logic [2:0]    wr_idx;
	logic [15:0]   wr_val;
	logic [15:0]   pc_nxt;
	logic          halt_nxt;

	logic          mem_we, mem_re;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [15:0]   mem_wd;

	assign op    = rdata_q[15:13];
	assign ra    = rdata_q[12:10];
	assign rb    = rdata_q[9:7];
	assign rc    = rdata_q[6:4];
	assign fn    = rdata_q[3:0];
	assign imm7  = {{9{rdata_q[6]}}, rdata_q[6:0]};
	assign imm13 = {3'b000, rdata_q[12:0]};
	assign va    = rf_q[ra];
	assign vb    = rf_q[rb];
	assign pc_inc = pc_q + 16'd1;
	assign dsum  = va + imm7;
	assign daddr = map_addr(dsum[12:0]);

	always_comb begin
		nxt   = pc_inc;
		x_we  = 1'b0;
		x_idx = rb;
		x_val = '0;
		x_lw  = 1'b0;
		x_sw  = 1'b0;
		case (op)
			OP_ALU: begin
				x_idx = rc;
				case (fn)
					FN_ADD: begin x_we = 1'b1; x_val = va + vb; end
					FN_SUB: begin x_we = 1'b1; x_val = va - vb; end
					FN_OR:  begin x_we = 1'b1; x_val = va | vb; end
					FN_AND: begin x_we = 1'b1; x_val = va & vb; end
					FN_SLT: begin x_we = 1'b1; x_val = {15'd0, va < vb}; end
					FN_JR:  nxt = va;
					default: ;
				endcase
			end
			OP_ADDI: begin x_we = 1'b1; x_val = dsum; end
			OP_J:    nxt = imm13;
			OP_JAL: begin
				x_we  = 1'b1;
				x_idx = LINK_REG;
				x_val = pc_inc;
				nxt   = imm13;
			end
			OP_LW:   x_lw = 1'b1;
			OP_SW:   x_sw = 1'b1;
			OP_JEQ: begin
				if (va == vb) begin
					nxt = pc_inc + imm7;
				end
			end
			OP_SLTI: begin x_we = 1'b1; x_val = {15'd0, va < imm7}; end
			default: ;
		endcase
	end

	assign out_free = !out_v_q || rsp.ready;
	assign s1_exec  = vld_s1 && (kind_s1 == REQ_EXEC) && !halt_q;
	assign s1_lw    = s1_exec && x_lw;
	assign s1_adv   = vld_s1 && (s1_lw || out_free);
	assign s2_adv   = vld_s2 && out_free;
	assign out_load = (s1_adv && !s1_lw) || s2_adv;
	assign rdy      = !clr_busy_q && (!vld_s1 || (s1_adv && !s1_exec)) && (!vld_s2 || s2_adv);
	assign acc      = req.valid && rdy;
	assign req.ready = rdy;

	always_comb begin
		if (vld_s2) begin
			wr_en  = 1'b1;
			wr_idx = dst_s2;
			wr_val = rdata_q;
		end else begin
			wr_en  = s1_exec && x_we;
			wr_idx = x_idx;
			wr_val = x_val;
		end
		for (int i = 0; i < 8; i++) begin
			rf_nxt[i] = rf_q[i];
		end
		if (wr_en && wr_idx != 3'd0) begin
			rf_nxt[wr_idx] = wr_val;
		end
		pc_nxt   = (s1_exec && nxt != pc_q) ? nxt : pc_q;
		halt_nxt = halt_q || (s1_exec && nxt == pc_q);
	end

	always_comb begin
		res.prog_counter = pc_nxt;
		res.halted       = halt_nxt;
		res.read_data    = (vld_s1 && kind_s1 == REQ_READ) ? rdata_q : 16'd0;
		res.reg_one      = rf_nxt[1];
		res.reg_two      = rf_nxt[2];
		res.reg_three    = rf_nxt[3];
		res.reg_four     = rf_nxt[4];
		res.reg_five     = rf_nxt[5];
		res.reg_six      = rf_nxt[6];
		res.reg_seven    = rf_nxt[7];
	end

	always_comb begin
		mem_we = clr_busy_q || (acc && req.req_type == REQ_WRITE) || (s1_adv && s1_exec && x_sw);
		mem_re = (acc && (req.req_type == REQ_READ || (req.req_type == REQ_EXEC && !halt_q)))
			|| (s1_adv && s1_lw);
		if (clr_busy_q) begin
			mem_wa = clr_q;
			mem_wd = '0;
		end else if (acc) begin
			mem_wa = map_addr(req.mem_addr);
			mem_wd = req.write_data;
		end else begin
			mem_wa = daddr;
			mem_wd = vb;
		end
		if (acc) begin
			mem_ra = (req.req_type == REQ_READ) ? map_addr(req.mem_addr) : map_addr(pc_q[12:0]);
		end else begin
			mem_ra = daddr;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rdata_q <= mem[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_q      <= '0;
		end else if (clr_busy_q) begin
			if (clr_q == AW'(MEMORY_WORDS - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_q <= clr_q + AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				rf_q[i] <= '0;
			end
			pc_q   <= '0;
			halt_q <= 1'b0;
		end else begin
			if (s2_adv || (s1_adv && s1_exec)) begin
				for (int i = 0; i < 8; i++) begin
					rf_q[i] <= rf_nxt[i];
				end
			end
			if (s1_adv && s1_exec) begin
				pc_q   <= pc_nxt;
				halt_q <= halt_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (acc) begin
				vld_s1 <= 1'b1;
			end else if (s1_adv) begin
				vld_s1 <= 1'b0;
			end
			if (s1_adv && s1_lw) begin
				vld_s2 <= 1'b1;
			end else if (s2_adv) begin
				vld_s2 <= 1'b0;
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			kind_s1 <= req.req_type;
		end
		if (s1_adv && s1_lw) begin
			dst_s2 <= rb;
		end
		if (out_load) begin
			out_q <= res;
		end
	end

	assign rsp.valid        = out_v_q;
	assign rsp.prog_counter = out_q.prog_counter;
	assign rsp.halted       = out_q.halted;
	assign rsp.read_data    = out_q.read_data;
	assign rsp.reg_one      = out_q.reg_one;
	assign rsp.reg_two      = out_q.reg_two;
	assign rsp.reg_three    = out_q.reg_three;
	assign rsp.reg_four     = out_q.reg_four;
	assign rsp.reg_five     = out_q.reg_five;
	assign rsp.reg_six      = out_q.reg_six;
	assign rsp.reg_seven    = out_q.reg_seven;

endmodule

### rtl/e20s_chk.sv
// Port checker for the instruction-step top level, attached by bind.
module e20s_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [15:0] prog_counter,
	input logic        halted
);
	import e20s_pkg::*;

	logic [2:0]  pend_q;
	logic        seen_halt_q;
	logic [15:0] halt_pc_q;
	logic        in_acc, out_acc;

	assign in_acc  = req_valid && req_ready;
	assign out_acc = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			seen_halt_q <= 1'b0;
			halt_pc_q   <= '0;
		end else begin
			pend_q <= pend_q + 3'(in_acc) - 3'(out_acc);
			if (out_acc && halted && !seen_halt_q) begin
				seen_halt_q <= 1'b1;
				halt_pc_q   <= prog_counter;
			end
		end
	end

	a_no_invented_word: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 3'd0)
		else $error("result word without a pending request");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && seen_halt_q) |-> halted)
		else $error("halted dropped after it was reported");

	a_halt_pc_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && seen_halt_q) |-> prog_counter == halt_pc_q)
		else $error("program counter moved while halted");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid && $stable(prog_counter) && $stable(halted))
		else $error("stalled result word changed");

endmodule

bind sixteen_bit_risc_instruction_step_top e20s_chk u_e20s_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.prog_counter (rsp.prog_counter),
	.halted       (rsp.halted)
);
